@@ hdl/utc_offset_text_parser_defines.svh @@
// Assertion macros used by the UTC offset text parser RTL.
`ifndef UTC_OFFSET_TEXT_PARSER_DEFINES_SVH
`define UTC_OFFSET_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define UOTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in utc_offset_text_parser");
`define UOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in utc_offset_text_parser");
`else
`define UOTP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/uotp_pkg.sv @@
// Types, constants and character functions of the UTC offset text parser.
`default_nettype none

package uotp_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ZED,
        PH_SIGN,
        PH_BODY,
        PH_BAD
    } t_phase;

    typedef struct packed {
        logic [2:0] body_length;
        logic       colon_seen;
        logic [6:0] lead_value;
        logic       lead_ok;
        logic [6:0] tail_value;
        logic       tail_ok;
        logic       tail_nonempty;
        logic [6:0] fixed_hours;
        logic [6:0] fixed_minutes;
        logic       fixed_ok;
    } t_body;

    typedef struct packed {
        logic       ok;
        logic       negative;
        logic [4:0] hours;
        logic [5:0] minutes;
    } t_verdict;

    localparam logic [7:0]  CH_SPACE = 8'd32;
    localparam logic [7:0]  CH_PLUS = 8'd43;
    localparam logic [7:0]  CH_MINUS = 8'd45;
    localparam logic [7:0]  CH_COLON = 8'd58;
    localparam logic [7:0]  CH_UPPER_Z = 8'd90;
    localparam logic [7:0]  CH_LOWER_Z = 8'd122;
    localparam logic [6:0]  ACC_MAX = 7'd99;
    localparam logic [6:0]  MAX_HOURS = 7'd18;
    localparam logic [6:0]  MAX_MINUTES = 7'd59;
    localparam logic [2:0]  FIXED_LENGTH = 3'd4;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MINUTE = 17'd60;

    localparam t_body BODY_RESET = '{
        body_length: 3'd0, colon_seen: 1'b0, lead_value: 7'd0, lead_ok: 1'b1,
        tail_value: 7'd0, tail_ok: 1'b1, tail_nonempty: 1'b0,
        fixed_hours: 7'd0, fixed_minutes: 7'd0, fixed_ok: 1'b1
    };

    function automatic logic is_blank(logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic [6:0] sat_acc(logic [6:0] acc, logic [3:0] d);
        logic [9:0] v;
        v = {3'b000, acc} * 10'd10 + {6'b000000, d};
        return (v > {3'b000, ACC_MAX}) ? ACC_MAX : v[6:0];
    endfunction

    function automatic t_body body_char(t_body b, logic [7:0] c);
        t_body      r;
        logic       dig;
        logic [3:0] d;
        logic [2:0] pos;
        r = b;
        pos = b.body_length;
        dig = is_digit(c);
        d = dig ? c[3:0] : 4'd0;
        if (pos < 3'd2) begin
            if (dig) r.fixed_hours = sat_acc(b.fixed_hours, d);
            else r.fixed_ok = 1'b0;
        end else if (pos < FIXED_LENGTH) begin
            if (dig) r.fixed_minutes = sat_acc(b.fixed_minutes, d);
            else r.fixed_ok = 1'b0;
        end
        if (!b.colon_seen) begin
            if (c == CH_COLON) begin
                r.colon_seen = 1'b1;
                if (pos == 3'd0) r.lead_ok = 1'b0;
            end else if (dig) begin
                r.lead_value = sat_acc(b.lead_value, d);
            end else begin
                r.lead_ok = 1'b0;
            end
        end else begin
            r.tail_nonempty = 1'b1;
            if (dig) r.tail_value = sat_acc(b.tail_value, d);
            else r.tail_ok = 1'b0;
        end
        r.body_length = (pos < FIXED_LENGTH) ? pos + 3'd1 : FIXED_LENGTH;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/uotp_if.sv @@
// Stream interfaces for the character input and the offset result of the parser.
`default_nettype none

interface uotp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
    modport source (output valid, output char_code, output has_char, output is_last,
                    input ready);
    modport sink (input valid, input char_code, input has_char, input is_last,
                  output ready);
endinterface

interface uotp_out_if;
    logic               valid;
    logic               ready;
    logic               offset_ok;
    logic signed [17:0] offset_seconds;
    modport source (output valid, output offset_ok, output offset_seconds, input ready);
    modport sink (input valid, input offset_ok, input offset_seconds, output ready);
endinterface

`default_nettype wire

@@ hdl/utc_offset_text_parser.sv @@
// UTC offset text parser: character stream in, offset verdict in seconds out.
//
// The input channel carries one character of the offset text per beat, with
// has_char to mark whether a beat carries a character and is_last to mark the
// final beat of a string. Only a beat with is_last set produces a result beat.
// The result carries offset_ok and the signed offset in seconds, or zero when
// the text is not a valid offset.
//
// Each beat updates the parser state in the cycle it is accepted, so one beat
// is taken per cycle while input ready is high. A final beat is judged into a
// verdict register, from which the seconds are formed into the output register.
// If the receiver stalls, the verdict and output registers hold two results;
// input ready falls only when both are full and the output is not taken.
// Synchronous reset empties both registers and returns the parser to the
// start of a string; the state also returns there after every final beat.
`default_nettype none
`include "utc_offset_text_parser_defines.svh"

module utc_offset_text_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    uotp_in_if.sink      i_in,
    uotp_out_if.source   o_out
);

    uotp_pkg::t_phase   r_phase, n_phase;
    logic               r_negative, n_negative;
    logic               r_pending, n_pending;
    uotp_pkg::t_body    r_body, n_body;

    logic               r_m_valid, n_m_valid;
    uotp_pkg::t_verdict r_verdict, n_verdict;
    logic               r_o_valid, n_o_valid;
    logic               r_o_ok;
    logic signed [17:0] r_o_seconds, n_o_seconds;

    logic               can_out;
    logic               in_accept;
    logic               last_accept;
    logic               blank;
    logic               fin_ok;
    logic [6:0]         fin_h;
    logic [6:0]         fin_m;
    uotp_pkg::t_body    flushed;
    logic [16:0]        magnitude;

    assign can_out = !r_o_valid || o_out.ready;
    assign i_in.ready = !r_m_valid || can_out;
    assign in_accept = i_in.valid && i_in.ready;
    assign last_accept = in_accept && i_in.is_last;

    always_comb begin
        n_phase = r_phase;
        n_negative = r_negative;
        n_pending = r_pending;
        n_body = r_body;
        flushed = r_body;
        blank = uotp_pkg::is_blank(i_in.char_code);
        if (in_accept && i_in.has_char) begin
            case (r_phase)
                uotp_pkg::PH_LEAD: begin
                    if (!blank) begin
                        if (i_in.char_code == uotp_pkg::CH_PLUS ||
                            i_in.char_code == uotp_pkg::CH_MINUS) begin
                            n_negative = (i_in.char_code == uotp_pkg::CH_MINUS);
                            n_phase = uotp_pkg::PH_SIGN;
                        end else if (i_in.char_code == uotp_pkg::CH_UPPER_Z ||
                                     i_in.char_code == uotp_pkg::CH_LOWER_Z) begin
                            n_phase = uotp_pkg::PH_ZED;
                        end else begin
                            n_phase = uotp_pkg::PH_BAD;
                        end
                    end
                end
                uotp_pkg::PH_ZED: begin
                    if (!blank) n_phase = uotp_pkg::PH_BAD;
                end
                uotp_pkg::PH_SIGN: begin
                    if (!blank) begin
                        n_phase = uotp_pkg::PH_BODY;
                        n_body = uotp_pkg::body_char(r_body, i_in.char_code);
                    end
                end
                uotp_pkg::PH_BODY: begin
                    if (blank) begin
                        n_pending = 1'b1;
                    end else begin
                        if (r_pending) begin
                            flushed = uotp_pkg::body_char(r_body, uotp_pkg::CH_SPACE);
                        end
                        n_pending = 1'b0;
                        n_body = uotp_pkg::body_char(flushed, i_in.char_code);
                    end
                end
                default: begin
                end
            endcase
        end

        fin_ok = 1'b0;
        fin_h = 7'd0;
        fin_m = 7'd0;
        if (n_phase == uotp_pkg::PH_LEAD || n_phase == uotp_pkg::PH_ZED) begin
            fin_ok = 1'b1;
        end else if (n_phase == uotp_pkg::PH_BODY) begin
            if (n_body.colon_seen) begin
                fin_ok = n_body.lead_ok && n_body.tail_ok && n_body.tail_nonempty;
                fin_h = n_body.lead_value;
                fin_m = n_body.tail_value;
            end else if (n_body.body_length >= uotp_pkg::FIXED_LENGTH) begin
                fin_ok = n_body.fixed_ok;
                fin_h = n_body.fixed_hours;
                fin_m = n_body.fixed_minutes;
            end else begin
                fin_ok = n_body.lead_ok;
                fin_h = n_body.lead_value;
            end
            if (fin_h > uotp_pkg::MAX_HOURS || fin_m > uotp_pkg::MAX_MINUTES) begin
                fin_ok = 1'b0;
            end
        end
        n_verdict.ok = fin_ok;
        n_verdict.negative = n_negative;
        n_verdict.hours = fin_ok ? fin_h[4:0] : 5'd0;
        n_verdict.minutes = fin_ok ? fin_m[5:0] : 6'd0;

        if (last_accept) begin
            n_phase = uotp_pkg::PH_LEAD;
            n_negative = 1'b0;
            n_pending = 1'b0;
            n_body = uotp_pkg::BODY_RESET;
        end

        n_m_valid = last_accept ? 1'b1 : (can_out ? 1'b0 : r_m_valid);
        n_o_valid = can_out ? r_m_valid : r_o_valid;

        magnitude = {12'd0, r_verdict.hours} * uotp_pkg::SEC_PER_HOUR
                  + {11'd0, r_verdict.minutes} * uotp_pkg::SEC_PER_MINUTE;
        n_o_seconds = r_verdict.negative ? -$signed({1'b0, magnitude})
                                         : $signed({1'b0, magnitude});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uotp_pkg::PH_LEAD;
            r_negative <= 1'b0;
            r_pending <= 1'b0;
            r_body <= uotp_pkg::BODY_RESET;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_negative <= n_negative;
            r_pending <= n_pending;
            r_body <= n_body;
            r_m_valid <= n_m_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_accept) begin
            r_verdict <= n_verdict;
        end
        if (can_out && r_m_valid) begin
            r_o_ok <= r_verdict.ok;
            r_o_seconds <= n_o_seconds;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.offset_ok = r_o_ok;
    assign o_out.offset_seconds = r_o_seconds;

    `UOTP_ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, r_o_valid && !r_o_ok, r_o_seconds == 18'sd0)
    `UOTP_ASSERT_NOW(a_in_range, i_clk, i_rst_n, r_o_valid,
        r_o_seconds <= 18'sd68340 && r_o_seconds >= -18'sd68340)
    `UOTP_ASSERT_NEXT(a_last_fills_verdict, i_clk, i_rst_n, last_accept, r_m_valid)
    `UOTP_ASSERT_NEXT(a_last_resets_state, i_clk, i_rst_n, last_accept,
        r_phase == uotp_pkg::PH_LEAD && !r_pending && r_body == uotp_pkg::BODY_RESET)
    `UOTP_ASSERT_NEXT(a_verdict_moves_out, i_clk, i_rst_n, r_m_valid && can_out, r_o_valid)

endmodule

`default_nettype wire

@@ verif/tb_utc_offset_text_parser.sv @@
// Self-checking testbench for the UTC offset text parser, driven by character beats.
`default_nettype none

module tb_utc_offset_text_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TEXT_BEATS = 1030;

    typedef struct {
        logic [7:0] code;
        logic       has;
        logic       last;
    } t_text_beat;

    typedef struct {
        logic               ok;
        logic signed [17:0] seconds;
    } t_offset;

    typedef struct {
        uotp_pkg::t_phase phase;
        bit               neg;
        bit               blank_run;
        int unsigned      body_len;
        bit               colon;
        int unsigned      lead;
        bit               lead_good;
        int unsigned      tail;
        bit               tail_good;
        bit               tail_seen;
        int unsigned      fix_h;
        int unsigned      fix_m;
        bit               fix_good;
    } t_parse_state;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uotp_in_if  in_bus ();
    uotp_out_if out_bus ();

    utc_offset_text_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_text_beat   beats_pending[$];
    t_offset      offsets_due[$];
    logic [7:0]   draft[$];
    t_parse_state text_state;
    int           total_beats;
    int           beats_taken = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           errors = 0;
    int           results_seen = 0;
    int           valid_results = 0;
    logic         quiet;

    assign quiet = (cycle_count >= 700) && (cycle_count < 1000);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit blank_byte(logic [7:0] c);
        return (c == uotp_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic int unsigned bump_acc(int unsigned a, int unsigned d);
        int unsigned v;
        v = a * 10 + d;
        return (v > uotp_pkg::ACC_MAX) ? uotp_pkg::ACC_MAX : v;
    endfunction

    function automatic t_parse_state fresh_parse();
        t_parse_state s;
        s.phase = uotp_pkg::PH_LEAD;
        s.neg = 1'b0;
        s.blank_run = 1'b0;
        s.body_len = 0;
        s.colon = 1'b0;
        s.lead = 0;
        s.lead_good = 1'b1;
        s.tail = 0;
        s.tail_good = 1'b1;
        s.tail_seen = 1'b0;
        s.fix_h = 0;
        s.fix_m = 0;
        s.fix_good = 1'b1;
        return s;
    endfunction

    function automatic t_parse_state step_body(t_parse_state s, logic [7:0] c);
        t_parse_state r;
        bit           dig;
        int unsigned  d;
        r = s;
        dig = digit_byte(c);
        d = dig ? c - 8'd48 : 0;
        if (s.body_len < 2) begin
            if (dig) r.fix_h = bump_acc(s.fix_h, d);
            else r.fix_good = 1'b0;
        end else if (s.body_len < uotp_pkg::FIXED_LENGTH) begin
            if (dig) r.fix_m = bump_acc(s.fix_m, d);
            else r.fix_good = 1'b0;
        end
        if (!s.colon) begin
            if (c == uotp_pkg::CH_COLON) begin
                r.colon = 1'b1;
                if (s.body_len == 0) r.lead_good = 1'b0;
            end else if (dig) begin
                r.lead = bump_acc(s.lead, d);
            end else begin
                r.lead_good = 1'b0;
            end
        end else begin
            r.tail_seen = 1'b1;
            if (dig) r.tail = bump_acc(s.tail, d);
            else r.tail_good = 1'b0;
        end
        r.body_len = (s.body_len < uotp_pkg::FIXED_LENGTH) ? s.body_len + 1
                                                            : uotp_pkg::FIXED_LENGTH;
        return r;
    endfunction

    function automatic t_parse_state step_char(t_parse_state s, logic [7:0] c);
        t_parse_state r;
        r = s;
        case (s.phase)
            uotp_pkg::PH_LEAD: begin
                if (!blank_byte(c)) begin
                    if (c == uotp_pkg::CH_PLUS || c == uotp_pkg::CH_MINUS) begin
                        r.neg = (c == uotp_pkg::CH_MINUS);
                        r.phase = uotp_pkg::PH_SIGN;
                    end else if (c == uotp_pkg::CH_UPPER_Z || c == uotp_pkg::CH_LOWER_Z) begin
                        r.phase = uotp_pkg::PH_ZED;
                    end else begin
                        r.phase = uotp_pkg::PH_BAD;
                    end
                end
            end
            uotp_pkg::PH_ZED: begin
                if (!blank_byte(c)) r.phase = uotp_pkg::PH_BAD;
            end
            uotp_pkg::PH_SIGN: begin
                if (!blank_byte(c)) begin
                    r.phase = uotp_pkg::PH_BODY;
                    r = step_body(r, c);
                end
            end
            uotp_pkg::PH_BODY: begin
                if (blank_byte(c)) begin
                    r.blank_run = 1'b1;
                end else begin
                    // A blank run inside the body counts as one non-digit character.
                    if (r.blank_run) begin
                        r.blank_run = 1'b0;
                        r = step_body(r, uotp_pkg::CH_SPACE);
                    end
                    r = step_body(r, c);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_offset judge_offset(t_parse_state s);
        t_offset     o;
        bit          good;
        int unsigned h;
        int unsigned m;
        int          secs;
        good = 1'b0;
        h = 0;
        m = 0;
        if (s.phase == uotp_pkg::PH_LEAD || s.phase == uotp_pkg::PH_ZED) begin
            good = 1'b1;
        end else if (s.phase == uotp_pkg::PH_BODY) begin
            if (s.colon) begin
                good = s.lead_good && s.tail_good && s.tail_seen;
                h = s.lead;
                m = s.tail;
            end else if (s.body_len >= uotp_pkg::FIXED_LENGTH) begin
                good = s.fix_good;
                h = s.fix_h;
                m = s.fix_m;
            end else begin
                good = s.lead_good;
                h = s.lead;
            end
            if (h > uotp_pkg::MAX_HOURS || m > uotp_pkg::MAX_MINUTES) good = 1'b0;
        end
        secs = good ? int'(h * uotp_pkg::SEC_PER_HOUR + m * uotp_pkg::SEC_PER_MINUTE) : 0;
        if (good && s.neg) secs = -secs;
        o.ok = good;
        o.seconds = secs[17:0];
        return o;
    endfunction

    task automatic put_blanks(int n);
        repeat (n) draft.push_back(($urandom_range(5) == 5) ? uotp_pkg::CH_SPACE
                                                             : 8'(9 + $urandom_range(4)));
    endtask

    task automatic put_number(int unsigned v, int w);
        int          i;
        int unsigned scale;
        for (i = w - 1; i >= 0; i--) begin
            scale = 1;
            repeat (i) scale = scale * 10;
            draft.push_back(8'(48 + (v / scale) % 10));
        end
    endtask

    task automatic put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endtask

    task automatic commit_draft(bit close_empty, bit fillers);
        t_text_beat b;
        int         i;
        for (i = 0; i < draft.size(); i++) begin
            if (fillers && $urandom_range(99) < 5) begin
                b.code = 8'($urandom_range(255));
                b.has = 1'b0;
                b.last = 1'b0;
                beats_pending.push_back(b);
            end
            b.code = draft[i];
            b.has = 1'b1;
            b.last = !close_empty && (i == draft.size() - 1);
            beats_pending.push_back(b);
        end
        if (close_empty || draft.size() == 0) begin
            b.code = 8'($urandom_range(255));
            b.has = 1'b0;
            b.last = 1'b1;
            beats_pending.push_back(b);
        end
        draft.delete();
    endtask

    task automatic compose_random();
        int          kind;
        int unsigned h;
        int unsigned m;
        int          spot;
        kind = $urandom_range(99);
        h = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(20);
        m = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(62);
        if ($urandom_range(3) == 0) put_blanks($urandom_range(1, 2));
        if (kind < 68) begin
            draft.push_back($urandom_range(1) ? uotp_pkg::CH_MINUS : uotp_pkg::CH_PLUS);
            if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
            if (kind < 30) begin
                put_number(h, $urandom_range(1, 2));
                draft.push_back(uotp_pkg::CH_COLON);
                put_number(m, $urandom_range(1, 2));
            end else if (kind < 48) begin
                put_number(h, 2);
                put_number(m, 2);
                repeat ($urandom_range(3)) draft.push_back(8'($urandom_range(255)));
            end else if (kind < 58) begin
                put_number(h, $urandom_range(1, 3));
            end else begin
                put_number(h, 2);
                draft.push_back(uotp_pkg::CH_COLON);
                put_number(m, 2);
                spot = $urandom_range(1, draft.size() - 1);
                if ($urandom_range(1)) draft[spot] = 8'($urandom_range(255));
                else draft.insert(spot, uotp_pkg::CH_SPACE);
            end
        end else if (kind < 76) begin
            draft.push_back($urandom_range(1) ? uotp_pkg::CH_UPPER_Z : uotp_pkg::CH_LOWER_Z);
        end else if (kind >= 82) begin
            repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0) put_blanks($urandom_range(1, 2));
        commit_draft($urandom_range(9) == 0, 1'b1);
    endtask

    always @(posedge i_clk) begin : drive_chars
        t_text_beat b;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (beats_pending.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
                b = beats_pending.pop_front();
                in_bus.valid <= 1'b1;
                in_bus.char_code <= b.code;
                in_bus.has_char <= b.has;
                in_bus.is_last <= b.last;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_taken >= 300) begin
            hold_left <= 200;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_bus.ready <= 1'b0;
        else out_bus.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin : score_offsets
        t_offset want;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                results_seen++;
                if (out_bus.offset_ok) valid_results++;
                if (offsets_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, ok=%0b seconds=%0d", $time,
                             out_bus.offset_ok, out_bus.offset_seconds);
                end else begin
                    want = offsets_due.pop_front();
                    if (out_bus.offset_ok !== want.ok) begin
                        errors++;
                        $display("%0t: offset_ok expected %0b, actual %0b", $time,
                                 want.ok, out_bus.offset_ok);
                    end
                    if (out_bus.offset_seconds !== want.seconds) begin
                        errors++;
                        $display("%0t: offset_seconds expected %0d, actual %0d", $time,
                                 want.seconds, out_bus.offset_seconds);
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                beats_taken <= beats_taken + 1;
                if (in_bus.has_char) text_state = step_char(text_state, in_bus.char_code);
                if (in_bus.is_last) begin
                    offsets_due.push_back(judge_offset(text_state));
                    text_state = fresh_parse();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int drain;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.char_code = 8'd0;
        in_bus.has_char = 1'b0;
        in_bus.is_last = 1'b0;
        out_bus.ready = 1'b0;
        text_state = fresh_parse();

        commit_draft(1'b1, 1'b0);
        put_text("z");
        commit_draft(1'b0, 1'b0);
        put_text("Z");
        draft.push_back(8'hFF);
        commit_draft(1'b0, 1'b0);
        draft.push_back(8'h00);
        commit_draft(1'b0, 1'b0);
        put_text("-");
        commit_draft(1'b1, 1'b0);
        put_text("+:5");
        commit_draft(1'b0, 1'b0);
        put_text("+1:2:");
        commit_draft(1'b0, 1'b0);
        put_text("-1859 ");
        commit_draft(1'b0, 1'b0);
        put_text("+999");
        commit_draft(1'b0, 1'b0);
        put_text("+0 1");
        commit_draft(1'b0, 1'b0);
        put_text("\t- 7");
        commit_draft(1'b0, 1'b0);

        while (beats_pending.size() < TEXT_BEATS) compose_random();
        total_beats = beats_pending.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (beats_taken < total_beats) @(posedge i_clk);
        drain = 0;
        while (offsets_due.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (offsets_due.size() != 0) begin
            errors += offsets_due.size();
            $display("%0t: %0d expected results never arrived", $time, offsets_due.size());
        end
        $display("Checked %0d offset results (%0d valid) from %0d character beats.",
                 results_seen, valid_results, total_beats);
        $display("Mix: colon, four-digit and hours-only bodies, Z, blanks, noise, output stall.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
